>>> design/vtq_pkg.sv
// Package for the virtual CPU timer queue: sizes, action and status codes,
// controller state type. No dependencies.
package vtq_pkg;

  localparam int SLOTS   = 16;
  localparam int ID_W    = 4;
  localparam int CNT_W   = 5;
  localparam int VAL_W   = 64;
  localparam int SLICE_W = 63;

  localparam logic [SLICE_W-1:0] MAX_SLICE_RST = 63'h7FFF_FFFF_FFFF_F000;

  localparam logic [2:0] ACT_ADD_ONESHOT  = 3'd0;
  localparam logic [2:0] ACT_ADD_PERIODIC = 3'd1;
  localparam logic [2:0] ACT_MODIFY       = 3'd2;
  localparam logic [2:0] ACT_DELETE       = 3'd3;
  localparam logic [2:0] ACT_INTERRUPT    = 3'd4;
  localparam logic [2:0] ACT_IDLE_STOP    = 3'd5;
  localparam logic [2:0] ACT_IDLE_START   = 3'd6;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_WAS_PENDING = 3'd1;
  localparam logic [2:0] ST_BAD_EXPIRY  = 3'd2;
  localparam logic [2:0] ST_ALREADY     = 3'd3;
  localparam logic [2:0] ST_STOP_REFUSE = 3'd4;
  localparam logic [2:0] ST_TABLE_FULL  = 3'd5;

  typedef enum logic [16:0] {
    S_IDLE    = 17'h00001,
    S_DISP    = 17'h00002,
    S_REB_RD  = 17'h00004,
    S_REB_WR  = 17'h00008,
    S_KEY_RD  = 17'h00010,
    S_KEY     = 17'h00020,
    S_INS_RD  = 17'h00040,
    S_INS_CMP = 17'h00080,
    S_INS_PUT = 17'h00100,
    S_HEAD_RD = 17'h00200,
    S_HEAD    = 17'h00400,
    S_INT_RD  = 17'h00800,
    S_INT_CHK = 17'h01000,
    S_FIRE    = 17'h02000,
    S_NX_RD   = 17'h04000,
    S_NX      = 17'h08000,
    S_FINAL   = 17'h10000
  } vtq_state_t;

endpackage

>>> design/vtq_in_if.sv
// Input channel of the timer queue: valid/ready plus one request word.
// Depends on vtq_pkg.
interface vtq_in_if import vtq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [2:0]              action;
  logic [ID_W-1:0]         timer_id;
  logic [SLICE_W-1:0]      expire_value;
  logic signed [VAL_W-1:0] cpu_timer_value;

  modport source (output valid, action, timer_id, expire_value, cpu_timer_value,
                  input ready);
  modport sink (input valid, action, timer_id, expire_value, cpu_timer_value,
                output ready);
endinterface

>>> design/vtq_out_if.sv
// Result channel of the timer queue: valid/ready plus one result word.
// Depends on vtq_pkg.
interface vtq_out_if import vtq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             is_expiry;
  logic [ID_W-1:0]  expired_id;
  logic [2:0]       status;
  logic             load_timer;
  logic [VAL_W-1:0] timer_load;
  logic             last;

  modport source (output valid, is_expiry, expired_id, status, load_timer, timer_load,
                  last, input ready);
  modport sink (input valid, is_expiry, expired_id, status, load_timer, timer_load,
                last, output ready);
endinterface

>>> design/virtual_cpu_timer_queue.sv
// Virtual CPU timer queue top level.
// Depends on vtq_pkg, vtq_in_if, vtq_out_if.
//
// One request word is taken at a time; in_ch.ready is high only when the
// controller is idle. Expiry and period values live in two 16-entry memories
// with registered reads; the queue order is a shifting register array.
// Delete, idle stop/start and invalid requests go from dispatch straight to
// the final word. Add and modify first sweep all 16 slots to rebase their
// expiries (a read state and a write state per slot) when the queue holds
// other timers, then insert the timer in sorted order. An interrupt removes
// each expired timer from the head, reports one word per expired timer and
// re-inserts each periodic one. Results wait in an output register, so a
// stalled sink holds the controller only when it must emit.
module virtual_cpu_timer_queue import vtq_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [SLICE_W-1:0] cfg_wdata,
  vtq_in_if.sink             in_ch,
  vtq_out_if.source          out_ch
);

  logic [VAL_W-1:0] exp_mem [SLOTS];
  logic [VAL_W-1:0] per_mem [SLOTS];
  logic [VAL_W-1:0] exp_rd_r, per_rd_r;
  logic             exp_we, per_we;
  logic [ID_W-1:0]  exp_waddr, exp_raddr;
  logic [VAL_W-1:0] exp_wdata, per_wdata;

  vtq_state_t         st_r, st_nxt;
  logic [SLICE_W-1:0] max_r, max_nxt;
  logic [SLOTS-1:0]   pend_r, pend_nxt, perio_r, perio_nxt;
  logic [ID_W-1:0]    order_r [SLOTS];
  logic [ID_W-1:0]    order_nxt [SLOTS];
  logic [ID_W-1:0]    fired_r [SLOTS];
  logic [ID_W-1:0]    fired_nxt [SLOTS];
  logic [CNT_W-1:0]   count_r, count_nxt, nf_r, nf_nxt, fi_r, fi_nxt, p_r, p_nxt;
  logic [ID_W-1:0]    sc_r, sc_nxt, ins_r, ins_nxt;
  logic [VAL_W-1:0]   elap_r, elap_nxt, loaded_r, loaded_nxt, idle_r, idle_nxt;
  logic [VAL_W-1:0]   done_r, done_nxt, key_r, key_nxt;
  logic               intm_r, intm_nxt;
  logic [2:0]         act_r, act_nxt;
  logic [ID_W-1:0]    id_r, id_nxt;
  logic [SLICE_W-1:0] xv_r, xv_nxt;
  logic [VAL_W-1:0]   cpu_r, cpu_nxt;
  logic [2:0]         rs_r, rs_nxt;
  logic               rl_r, rl_nxt;
  logic [VAL_W-1:0]   rv_r, rv_nxt;

  logic             ov_r, ov_nxt, oexp_r, oexp_nxt, olast_r, olast_nxt, oload_r, oload_nxt;
  logic [ID_W-1:0]  oid_r, oid_nxt;
  logic [2:0]       ost_r, ost_nxt;
  logic [VAL_W-1:0] oval_r, oval_nxt;

  logic             out_free, xv_ok, take;
  logic [ID_W-1:0]  rid, h;
  logic [SLOTS-1:0] seen;
  logic [ID_W-1:0]  rem_order [SLOTS];
  logic [CNT_W-1:0] reb_cnt;
  logic [VAL_W-1:0] xv64, max64;

  assign out_free = !ov_r || out_ch.ready;
  assign take     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (st_r == S_IDLE);
  assign xv64  = {1'b0, xv_r};
  assign max64 = {1'b0, max_r};
  assign xv_ok = (xv_r != '0) && (xv_r <= max_r);

  assign out_ch.valid      = ov_r;
  assign out_ch.is_expiry  = oexp_r;
  assign out_ch.expired_id = oid_r;
  assign out_ch.status     = ost_r;
  assign out_ch.load_timer = oload_r;
  assign out_ch.timer_load = oval_r;
  assign out_ch.last       = olast_r;

  // queue removal of slot rid: entries at and after its position move up
  assign rid = (st_r == S_INT_CHK) ? order_r[0] : id_r;
  always_comb begin
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < SLOTS; k++) begin
      hit = hit || ((order_r[k] == rid) && (CNT_W'(k) < count_r));
      seen[k] = hit;
    end
    for (int k = 0; k < SLOTS; k++) begin
      if (seen[k] && k < SLOTS - 1) rem_order[k] = order_r[(k + 1) % SLOTS];
      else                          rem_order[k] = order_r[k];
    end
  end

  always_comb begin
    exp_raddr = id_r;
    case (st_r)
      S_IDLE:   exp_raddr = in_ch.timer_id;
      S_REB_RD: exp_raddr = sc_r;
      S_KEY_RD: exp_raddr = ins_r;
      S_INS_RD: exp_raddr = order_r[p_r[ID_W-1:0]];
      S_HEAD_RD, S_INT_RD, S_NX_RD: exp_raddr = order_r[0];
      default:  exp_raddr = id_r;
    endcase
  end

  always_comb begin
    st_nxt = st_r;  max_nxt = cfg_we ? cfg_wdata : max_r;
    pend_nxt = pend_r;  perio_nxt = perio_r;
    order_nxt = order_r;  fired_nxt = fired_r;
    count_nxt = count_r;  nf_nxt = nf_r;  fi_nxt = fi_r;  p_nxt = p_r;
    sc_nxt = sc_r;  ins_nxt = ins_r;
    elap_nxt = elap_r;  loaded_nxt = loaded_r;  idle_nxt = idle_r;
    done_nxt = done_r;  key_nxt = key_r;  intm_nxt = intm_r;
    act_nxt = act_r;  id_nxt = id_r;  xv_nxt = xv_r;  cpu_nxt = cpu_r;
    rs_nxt = rs_r;  rl_nxt = rl_r;  rv_nxt = rv_r;
    exp_we = 1'b0;  exp_waddr = id_r;  exp_wdata = xv64;
    per_we = 1'b0;  per_wdata = xv64;
    reb_cnt = count_r;
    h = fired_r[fi_r[ID_W-1:0]];
    ov_nxt = ov_r && !out_ch.ready;
    oexp_nxt = oexp_r;  oid_nxt = oid_r;  ost_nxt = ost_r;
    oload_nxt = oload_r;  oval_nxt = oval_r;  olast_nxt = olast_r;

    case (st_r)
      S_IDLE: begin
        if (take) begin
          act_nxt = in_ch.action;  id_nxt = in_ch.timer_id;
          xv_nxt = in_ch.expire_value;  cpu_nxt = in_ch.cpu_timer_value;
          intm_nxt = 1'b0;
          st_nxt = S_DISP;
        end
      end
      S_DISP: begin
        st_nxt = S_FINAL;  rs_nxt = ST_OK;  rl_nxt = 1'b0;  rv_nxt = '0;
        case (act_r)
          ACT_ADD_ONESHOT, ACT_ADD_PERIODIC, ACT_MODIFY: begin
            if (!xv_ok) begin
              rs_nxt = ST_BAD_EXPIRY;
            end else if (act_r != ACT_MODIFY && pend_r[id_r]) begin
              rs_nxt = ST_ALREADY;
            end else if (act_r == ACT_MODIFY && pend_r[id_r] && exp_rd_r == xv64) begin
              rs_nxt = ST_WAS_PENDING;
            end else begin
              exp_we = 1'b1;  per_we = 1'b1;  ins_nxt = id_r;
              if (act_r == ACT_MODIFY && pend_r[id_r]) begin
                order_nxt = rem_order;
                count_nxt = count_r - 1'b1;
                reb_cnt = count_r - 1'b1;
                rs_nxt = ST_WAS_PENDING;
              end else begin
                pend_nxt[id_r] = 1'b1;
                perio_nxt[id_r] = (act_r == ACT_ADD_PERIODIC);
              end
              elap_nxt = '0;
              if (reb_cnt == '0) begin
                st_nxt = S_KEY_RD;
              end else begin
                done_nxt = loaded_r - cpu_r + elap_r;
                sc_nxt = '0;
                st_nxt = S_REB_RD;
              end
            end
          end
          ACT_DELETE: begin
            if (pend_r[id_r]) begin
              order_nxt = rem_order;
              count_nxt = count_r - 1'b1;
              pend_nxt[id_r] = 1'b0;
              if (count_r == CNT_W'(1)) begin
                loaded_nxt = '0;  elap_nxt = '0;
              end
              rs_nxt = ST_WAS_PENDING;
            end
          end
          ACT_INTERRUPT: begin
            if (loaded_r < max64) elap_nxt = elap_r + loaded_r;
            nf_nxt = '0;  fi_nxt = '0;  intm_nxt = 1'b1;
            st_nxt = S_INT_RD;
          end
          ACT_IDLE_STOP: begin
            if (count_r != '0 && cpu_r[VAL_W-1]) begin
              rs_nxt = ST_STOP_REFUSE;
            end else begin
              if (count_r == '0) begin
                idle_nxt = max64;
              end else begin
                elap_nxt = elap_r + loaded_r - cpu_r;
                idle_nxt = cpu_r;
              end
              loaded_nxt = max64;  rl_nxt = 1'b1;  rv_nxt = max64;
            end
          end
          ACT_IDLE_START: begin
            loaded_nxt = idle_r;  rl_nxt = 1'b1;  rv_nxt = idle_r;
          end
          default: rs_nxt = ST_OK;
        endcase
      end
      S_REB_RD: st_nxt = S_REB_WR;
      S_REB_WR: begin
        if (pend_r[sc_r] && sc_r != id_r) begin
          exp_we = 1'b1;  exp_waddr = sc_r;  exp_wdata = exp_rd_r - done_r;
        end
        sc_nxt = sc_r + 1'b1;
        st_nxt = (sc_r == ID_W'(SLOTS - 1)) ? S_KEY_RD : S_REB_RD;
      end
      S_KEY_RD: st_nxt = S_KEY;
      S_KEY: begin
        key_nxt = exp_rd_r;  p_nxt = '0;  st_nxt = S_INS_RD;
      end
      S_INS_RD: st_nxt = (p_r < count_r) ? S_INS_CMP : S_INS_PUT;
      S_INS_CMP: begin
        if (exp_rd_r > key_r) begin
          st_nxt = S_INS_PUT;
        end else begin
          p_nxt = p_r + 1'b1;  st_nxt = S_INS_RD;
        end
      end
      S_INS_PUT: begin
        for (int k = 0; k < SLOTS; k++) begin
          if (CNT_W'(k) == p_r)     order_nxt[k] = ins_r;
          else if (CNT_W'(k) > p_r) order_nxt[k] = order_r[(k + SLOTS - 1) % SLOTS];
        end
        count_nxt = count_r + 1'b1;
        if (intm_r) begin
          fi_nxt = fi_r + 1'b1;  st_nxt = S_FIRE;
        end else begin
          st_nxt = S_HEAD_RD;
        end
      end
      S_HEAD_RD: st_nxt = S_HEAD;
      S_HEAD: begin
        loaded_nxt = exp_rd_r;  rl_nxt = 1'b1;  rv_nxt = exp_rd_r;  st_nxt = S_FINAL;
      end
      S_INT_RD: st_nxt = (count_r != '0) ? S_INT_CHK : S_FIRE;
      S_INT_CHK: begin
        if (exp_rd_r <= elap_r) begin
          if (perio_r[order_r[0]]) begin
            exp_we = 1'b1;  exp_waddr = order_r[0];  exp_wdata = per_rd_r + elap_r;
          end
          order_nxt = rem_order;
          count_nxt = count_r - 1'b1;
          fired_nxt[nf_r[ID_W-1:0]] = order_r[0];
          nf_nxt = nf_r + 1'b1;
          st_nxt = S_INT_RD;
        end else begin
          st_nxt = S_FIRE;
        end
      end
      S_FIRE: begin
        if (fi_r < nf_r) begin
          if (out_free) begin
            ov_nxt = 1'b1;  oexp_nxt = 1'b1;  oid_nxt = h;  ost_nxt = ST_OK;
            oload_nxt = 1'b0;  oval_nxt = '0;  olast_nxt = 1'b0;
            if (perio_r[h]) begin
              ins_nxt = h;  st_nxt = S_KEY_RD;
            end else begin
              pend_nxt[h] = 1'b0;  fi_nxt = fi_r + 1'b1;
            end
          end
        end else if (count_r != '0) begin
          st_nxt = S_NX_RD;
        end else begin
          elap_nxt = '0;  loaded_nxt = max64;
          rs_nxt = ST_OK;  rl_nxt = 1'b1;  rv_nxt = max64;  st_nxt = S_FINAL;
        end
      end
      S_NX_RD: st_nxt = S_NX;
      S_NX: begin
        loaded_nxt = exp_rd_r - elap_r + cpu_r;
        elap_nxt = elap_r - cpu_r;
        rs_nxt = ST_OK;  rl_nxt = 1'b1;  rv_nxt = exp_rd_r - elap_r + cpu_r;
        st_nxt = S_FINAL;
      end
      S_FINAL: begin
        if (out_free) begin
          ov_nxt = 1'b1;  oexp_nxt = 1'b0;  oid_nxt = '0;  ost_nxt = rs_r;
          oload_nxt = rl_r;  oval_nxt = rv_r;  olast_nxt = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (exp_we) exp_mem[exp_waddr] <= exp_wdata;
    if (per_we) per_mem[id_r] <= per_wdata;
    exp_rd_r <= exp_mem[exp_raddr];
    per_rd_r <= per_mem[exp_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;  max_r <= MAX_SLICE_RST;
      pend_r <= '0;  perio_r <= '0;  count_r <= '0;
      elap_r <= '0;  loaded_r <= '0;  idle_r <= '0;
      ov_r <= 1'b0;  intm_r <= 1'b0;
    end else begin
      st_r <= st_nxt;  max_r <= max_nxt;
      pend_r <= pend_nxt;  perio_r <= perio_nxt;  count_r <= count_nxt;
      elap_r <= elap_nxt;  loaded_r <= loaded_nxt;  idle_r <= idle_nxt;
      ov_r <= ov_nxt;  intm_r <= intm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    order_r <= order_nxt;  fired_r <= fired_nxt;
    nf_r <= nf_nxt;  fi_r <= fi_nxt;  p_r <= p_nxt;
    sc_r <= sc_nxt;  ins_r <= ins_nxt;  done_r <= done_nxt;  key_r <= key_nxt;
    act_r <= act_nxt;  id_r <= id_nxt;  xv_r <= xv_nxt;  cpu_r <= cpu_nxt;
    rs_r <= rs_nxt;  rl_r <= rl_nxt;  rv_r <= rv_nxt;
    oexp_r <= oexp_nxt;  oid_r <= oid_nxt;  ost_r <= ost_nxt;
    oload_r <= oload_nxt;  oval_r <= oval_nxt;  olast_r <= olast_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'($countones(pend_r)))
    else $error("queue count exceeds pending slots");

  a_expiry_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && oexp_r |-> !olast_r && !oload_r)
    else $error("expiry word marked last or load");

  a_final_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_FINAL && out_free |=> st_r == S_IDLE && ov_r && olast_r)
    else $error("final word not issued");

  a_fire_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_FIRE |-> fi_r <= nf_r)
    else $error("fire index past fired count");

endmodule
